@@ rtl/pidl_pkg.sv @@
// Package for the positional insert/delete list: field widths, request modes,
// status codes and the request and list-view structs. No dependencies.
package pidl_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int POS_W        = 5;
    localparam int DATA_W       = 32;
    localparam int CNT_OUT_W    = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [CNT_OUT_W-1:0]     count;
        logic                     has_entries;
        logic signed [DATA_W-1:0] first_value;
        logic signed [DATA_W-1:0] last_value;
    } t_view;

endpackage

@@ rtl/pidl_list.sv @@
// Entry store of the positional list: one register per slot with parallel
// shifting, the entry count, range checks and the front/back view. Uses pidl_pkg.
module pidl_list #(
    parameter int CAPACITY = pidl_pkg::DEF_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  pidl_pkg::t_req    i_req,
    output logic [1:0]        o_status,
    output pidl_pkg::t_view   o_view
);
    import pidl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic signed [DATA_W-1:0] r_entries [CAPACITY];
    logic signed [DATA_W-1:0] n_entries [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [EXT_W-1:0]         ext_count;
    logic [EXT_W-1:0]         ext_pos;
    logic [CNT_W-1:0]         count_m1;
    logic [IDX_W-1:0]         last_idx;
    logic                     do_ins;
    logic                     do_rem;
    logic                     has;

    assign ext_count = EXT_W'(r_count);
    assign ext_pos   = EXT_W'(i_req.position);

    // The range check comes before the full check on insert.
    always_comb begin
        o_status = ST_DONE;
        if (i_req.mode == MODE_INSERT) begin
            if (ext_pos > ext_count) begin
                o_status = ST_RANGE;
            end else if (r_count == CNT_W'(CAPACITY)) begin
                o_status = ST_FULL;
            end
        end else begin
            if (ext_pos >= ext_count) begin
                o_status = ST_RANGE;
            end
        end
    end

    assign do_ins = i_en && (i_req.mode == MODE_INSERT) && (o_status == ST_DONE);
    assign do_rem = i_en && (i_req.mode == MODE_REMOVE) && (o_status == ST_DONE);

    // Each slot picks its own old value, its lower neighbor, its upper
    // neighbor or the new value.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        localparam logic [EXT_W-1:0] IDX = EXT_W'(g);
        always_comb begin
            n_entries[g] = r_entries[g];
            if (do_ins) begin
                if (IDX == ext_pos) begin
                    n_entries[g] = i_req.value;
                end else if (IDX > ext_pos) begin
                    n_entries[g] = r_entries[(g > 0) ? g - 1 : 0];
                end
            end else if (do_rem) begin
                if (IDX >= ext_pos) begin
                    n_entries[g] = r_entries[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign has      = (r_count != '0);
    assign count_m1 = r_count - 1'b1;
    assign last_idx = count_m1[IDX_W-1:0];

    always_comb begin
        o_view.count       = ext_count[CNT_OUT_W-1:0];
        o_view.has_entries = has;
        o_view.first_value = has ? r_entries[0] : '0;
        o_view.last_value  = has ? r_entries[last_idx] : '0;
    end

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_ins_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> r_count == $past(r_count) + 1'b1)
        else $error("completed insert did not grow the list by one");

    a_reject_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_status != ST_DONE) |=> $stable(r_count))
        else $error("rejected request changed the entry count");

    a_front_insert : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_ins && ext_pos == '0) |=> r_entries[0] == $past(i_req.value))
        else $error("insert at the front did not land in slot zero");

endmodule

@@ rtl/positional_insert_delete_list.sv @@
// Top level of the positional insert/delete list: input register, result
// register and handshakes around the entry store. Uses pidl_pkg and pidl_list.
//
//  Channel  | Valid        | Ready        | Payload
//  ---------+--------------+--------------+---------------------------------------------
//  request  | i_in_valid   | o_in_ready   | i_mode, i_position, i_value
//  result   | o_out_valid  | i_out_ready  | o_status, o_count, o_has_entries,
//           |              |              | o_first_value, o_last_value
//
// A request transfer is registered in the request register. When the result register
// can take a new result, the request is applied to the store as its status is loaded.
// One request can complete per cycle while results are taken; all slots shift in
// parallel in one step. Reset empties the list at once; slot contents are not cleared
// and are never shown. A stalled result holds the store too, so the request register
// fills and then o_in_ready drops until the result transfer takes place.
module positional_insert_delete_list #(
    parameter int CAPACITY = pidl_pkg::DEF_CAPACITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_mode,
    input  logic [pidl_pkg::POS_W-1:0]           i_position,
    input  logic signed [pidl_pkg::DATA_W-1:0]   i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_status,
    output logic [pidl_pkg::CNT_OUT_W-1:0]       o_count,
    output logic                                 o_has_entries,
    output logic signed [pidl_pkg::DATA_W-1:0]   o_first_value,
    output logic signed [pidl_pkg::DATA_W-1:0]   o_last_value
);
    import pidl_pkg::*;

    logic       r_in_vld;
    t_req       r_req;
    logic       r_out_vld;
    logic [1:0] r_status;
    logic       w_adv;
    logic       w_en;
    logic [1:0] w_status;
    t_view      w_view;

    // The result stage can take a new result when it is empty or being drained.
    assign w_adv      = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_en       = r_in_vld && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req.mode     <= i_mode;
            r_req.position <= i_position;
            r_req.value    <= i_value;
        end
    end

    pidl_list #(
        .CAPACITY (CAPACITY)
    ) u_list (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_req    (r_req),
        .o_status (w_status),
        .o_view   (w_view)
    );

    // The store changes only when a result is loaded, so the count and the
    // front and back values always belong to the result on offer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_status <= w_status;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_status;
    assign o_count       = w_view.count;
    assign o_has_entries = w_view.has_entries;
    assign o_first_value = w_view.first_value;
    assign o_last_value  = w_view.last_value;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for positional_insert_delete_list: a directed table and then
// random requests, each checked against a predictor of the list. Depends on pidl_pkg.
module tb;
    import pidl_pkg::*;

    localparam int CAPACITY   = DEF_CAPACITY;
    localparam int IDLE_LIMIT = 1000;  // cycles without any transfer before giving up
    localparam int TAIL_WAIT  = 8;     // cycles to wait after the final drain
    localparam int PHASE_DONE = 600;   // effective requests per idling phase
    localparam int DIR_MAX    = 32;    // room in the directed table
    localparam int PEND_DEPTH = 8;     // room for results still owed by the block

    // One result as the block reports it: the status and the view of the list.
    typedef struct packed {
        logic [1:0] status;
        t_view      view;
    } t_list_result;

    // A row of the directed table. Rows with has_typed set carry an expectation
    // that is written out by hand; the others are predicted.
    typedef struct packed {
        t_req         req;
        logic         has_typed;
        t_list_result want;
    } t_dir_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_mode;
    logic [POS_W-1:0]            i_position;
    logic signed [DATA_W-1:0]    i_value;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [1:0]                  o_status;
    logic [CNT_OUT_W-1:0]        o_count;
    logic                        o_has_entries;
    logic signed [DATA_W-1:0]    o_first_value;
    logic signed [DATA_W-1:0]    o_last_value;

    positional_insert_delete_list #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_count       (o_count),
        .o_has_entries (o_has_entries),
        .o_first_value (o_first_value),
        .o_last_value  (o_last_value)
    );

    // Predicted contents of the list and the results still owed by the block.
    // The owed results sit in a small ring, oldest at pend_rd.
    logic signed [DATA_W-1:0] list_slots [CAPACITY];
    int                       list_len;
    t_list_result             pend_buf [PEND_DEPTH];
    logic [2:0]               pend_wr;
    logic [2:0]               pend_rd;
    int                       pend_count;
    t_dir_row                 dir_rows [DIR_MAX];
    int                       dir_count;

    int fail_count;
    int idle_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_list_result make_result(logic [1:0] status, int count,
                                                 logic has, logic signed [DATA_W-1:0] first,
                                                 logic signed [DATA_W-1:0] last);
        t_list_result r;
        r.status           = status;
        r.view.count       = CNT_OUT_W'(count);
        r.view.has_entries = has;
        r.view.first_value = first;
        r.view.last_value  = last;
        return r;
    endfunction

    // Appends one expectation behind the others that are still owed.
    task automatic owe_result(t_list_result r);
        pend_buf[pend_wr] = r;
        pend_wr           = pend_wr + 3'd1;
        pend_count++;
    endtask

    // Takes the oldest owed expectation.
    function automatic t_list_result take_result();
        t_list_result r;
        r          = pend_buf[pend_rd];
        pend_rd    = pend_rd + 3'd1;
        pend_count--;
        return r;
    endfunction

    // Applies one request to the predicted list and returns the result it causes.
    // Inserts check the position before the capacity; removes need a position
    // strictly below the current length.
    function automatic t_list_result apply_list_request(t_req req);
        t_list_result r;
        int           pos;
        pos      = int'(req.position);
        r.status = ST_DONE;
        if (req.mode == MODE_INSERT) begin
            if (pos > list_len) begin
                r.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                for (int i = list_len; i > pos; i--) list_slots[i] = list_slots[i-1];
                list_slots[pos] = req.value;
                list_len++;
            end
        end else begin
            if (pos >= list_len) begin
                r.status = ST_RANGE;
            end else begin
                for (int i = pos; i + 1 < list_len; i++) list_slots[i] = list_slots[i+1];
                list_len--;
            end
        end
        r.view.count       = CNT_OUT_W'(list_len);
        r.view.has_entries = (list_len > 0);
        r.view.first_value = (list_len > 0) ? list_slots[0] : '0;
        r.view.last_value  = (list_len > 0) ? list_slots[list_len-1] : '0;
        return r;
    endfunction

    // Offers one request, called just after a falling edge. The sender may idle
    // first; once valid is raised it stays up with a fixed payload until the
    // transfer. Returns at the falling edge after the transfer, valid still high.
    task automatic send_request(t_req req, logic has_typed, t_list_result want,
                                output logic [1:0] status);
        t_list_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_mode     = req.mode;
        i_position = req.position;
        i_value    = req.value;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_list_request(req);
        owe_result(has_typed ? want : predicted);
        status = predicted.status;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every owed result has been transferred.
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pend_count != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_row(logic mode, int pos, logic signed [DATA_W-1:0] val,
                           logic has_typed, t_list_result want);
        t_dir_row row;
        row.req.mode     = mode;
        row.req.position = POS_W'(pos);
        row.req.value    = val;
        row.has_typed    = has_typed;
        row.want         = want;
        dir_rows[dir_count] = row;
        dir_count++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: ready is redrawn on every falling edge.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: every result transfer is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pend_count == 0) begin
                $error("result transfer with no request outstanding");
                fail_count++;
            end else begin
                want = take_result();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_count !== want.view.count) begin
                    $error("count: expected %0d, actual %0d", want.view.count, o_count);
                    fail_count++;
                end
                if (o_has_entries !== want.view.has_entries) begin
                    $error("has_entries: expected %0d, actual %0d",
                           want.view.has_entries, o_has_entries);
                    fail_count++;
                end
                if (o_first_value !== want.view.first_value) begin
                    $error("first_value: expected %0d, actual %0d",
                           want.view.first_value, o_first_value);
                    fail_count++;
                end
                if (o_last_value !== want.view.last_value) begin
                    $error("last_value: expected %0d, actual %0d",
                           want.view.last_value, o_last_value);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        t_list_result none;
        t_req         req;
        logic [1:0]   status;
        logic         grow;
        int           done_items;
        int           roll;

        none          = '0;
        fail_count    = 0;
        list_len      = 0;
        pend_wr       = '0;
        pend_rd       = '0;
        pend_count    = 0;
        dir_count     = 0;
        send_idle_pct = 13;
        recv_idle_pct = 59;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_INSERT;
        i_position    = '0;
        i_value       = '0;
        for (int i = 0; i < CAPACITY; i++) list_slots[i] = '0;

        // Directed table. The first rows start from an empty list and read off
        // directly; the rest fill the list to capacity and probe the full case.
        add_row(MODE_REMOVE, 0, 32'sd0, 1'b1, make_result(ST_RANGE, 0, 1'b0, 0, 0));
        add_row(MODE_INSERT, 1, 32'sd5, 1'b1, make_result(ST_RANGE, 0, 1'b0, 0, 0));
        add_row(MODE_INSERT, 0, 32'sh7FFF_FFFF, 1'b1,
                make_result(ST_DONE, 1, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        add_row(MODE_INSERT, 1, 32'sh8000_0000, 1'b1,
                make_result(ST_DONE, 2, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000));
        add_row(MODE_INSERT, 31, -32'sd1, 1'b1,
                make_result(ST_RANGE, 2, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000));
        add_row(MODE_REMOVE, 31, -32'sd1, 1'b1,
                make_result(ST_RANGE, 2, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000));
        add_row(MODE_REMOVE, 2, 32'sd0, 1'b1,
                make_result(ST_RANGE, 2, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000));
        add_row(MODE_INSERT, 1, 32'sd0, 1'b0, none);
        add_row(MODE_INSERT, 0, 32'sh5555_5555, 1'b0, none);
        add_row(MODE_INSERT, 4, 32'shAAAA_AAAA, 1'b0, none);
        add_row(MODE_INSERT, 1, 32'sd1, 1'b0, none);
        add_row(MODE_INSERT, 6, -32'sd2, 1'b0, none);
        add_row(MODE_INSERT, 3, 32'sh0F0F_0F0F, 1'b0, none);
        add_row(MODE_INSERT, 8, 32'shF0F0_F0F0, 1'b0, none);
        add_row(MODE_INSERT, 0, 32'sh1234_5678, 1'b0, none);
        add_row(MODE_INSERT, 10, 32'sh8765_4321, 1'b0, none);
        add_row(MODE_INSERT, 5, 32'sd100, 1'b0, none);
        add_row(MODE_INSERT, 12, -32'sd100, 1'b0, none);
        add_row(MODE_INSERT, 13, 32'sh0000_FFFF, 1'b0, none);
        add_row(MODE_INSERT, 7, 32'shFFFF_0000, 1'b0, none);
        add_row(MODE_INSERT, 15, 32'sh3C3C_3C3C, 1'b0, none);
        // The list is full now: position at the end is in range but refused as
        // full, one past the end is refused as out of range first.
        add_row(MODE_INSERT, 16, 32'sd7, 1'b0, none);
        add_row(MODE_INSERT, 17, 32'sd7, 1'b0, none);
        add_row(MODE_REMOVE, 15, 32'sd0, 1'b0, none);
        add_row(MODE_REMOVE, 0, 32'sd0, 1'b0, none);

        // Synchronous reset, released on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < dir_count; k++)
            send_request(dir_rows[k].req, dir_rows[k].has_typed, dir_rows[k].want, status);
        drain_results();

        // Random part in three idling phases. Most requests are well formed, with
        // positions leaning toward the two ends; a tenth use any position at all.
        // The fill trend swings between empty and full so both ends are visited.
        grow = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 13 : 0;
            done_items    = 0;
            while (done_items < PHASE_DONE) begin
                if (list_len == CAPACITY) grow = 1'b0;
                if (list_len == 0) grow = 1'b1;
                if ($urandom_range(99) < 2) grow = ~grow;
                req.value = pick_value();
                roll      = $urandom_range(99);
                if (roll < 10) begin
                    req.mode     = 1'($urandom_range(1));
                    req.position = POS_W'($urandom_range(31));
                end else begin
                    req.mode = ($urandom_range(99) < (grow ? 75 : 25)) ? MODE_INSERT
                                                                       : MODE_REMOVE;
                    case ($urandom_range(3))
                        0: req.position = '0;
                        1: req.position = (req.mode == MODE_INSERT || list_len == 0)
                                          ? POS_W'(list_len) : POS_W'(list_len - 1);
                        default: req.position = (req.mode == MODE_INSERT || list_len == 0)
                                                ? POS_W'($urandom_range(list_len))
                                                : POS_W'($urandom_range(list_len - 1));
                    endcase
                end
                send_request(req, 1'b0, none, status);
                if (status == ST_DONE) done_items++;
                // Now and then the sender waits for the pipeline to run dry.
                if ($urandom_range(299) == 0) drain_results();
            end
        end

        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ positional_insert_delete_list.f @@
rtl/pidl_pkg.sv
rtl/pidl_list.sv
rtl/positional_insert_delete_list.sv
verif/tb.sv
